FILE: rtl/dqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqd_pkg
// Shared types and codes for the double-ended queue with delete
// ----------------------------------------------------------------------------
package dqd_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // fixed field widths of the channels
    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOMATCH = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic sample;
        logic push_front;
        logic push_back;
        logic pop_front;
        logic del;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/dqd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqd_if
// Valid/ready channels for requests, results and the mask register
// ----------------------------------------------------------------------------
interface dqd_req_if;
    import dqd_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   value;
    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dqd_res_if;
    import dqd_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   popped_value;
    logic [COUNT_W-1:0]  entry_count;
    modport source (output valid, output status, output popped_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input entry_count, output ready);
endinterface

interface dqd_cfg_if;
    import dqd_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dqd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqd_cell
// One queue position: holds a word, matches it and shifts with its neighbours
// ----------------------------------------------------------------------------
module dqd_cell #(
    parameter int DATA_W = dqd_pkg::DATA_W_DEF
) (
    input  wire                      clk,
    input  dqd_pkg::cell_ctrl_t      ctrl,
    input  wire  [DATA_W-1:0]        cmp_value,
    input  wire  [DATA_W-1:0]        cmp_mask,
    input  wire  [DATA_W-1:0]        wr_value,
    input  wire                      occ,
    input  wire                      prev_occ,
    input  wire                      next_occ,
    input  wire  [DATA_W-1:0]        prev_data,
    input  wire  [DATA_W-1:0]        next_data,
    input  wire                      found_in,
    output logic                     found_out,
    input  wire  [DATA_W-1:0]        tail_in,
    output logic [DATA_W-1:0]        tail_out,
    output logic                     is_last,
    output logic [DATA_W-1:0]        data
);
    import dqd_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    assign is_last   = occ && !next_occ;
    assign found_out = found_in || match_reg;
    assign tail_out  = tail_in | (is_last ? data_reg : '0);
    assign data      = data_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.sample)
        begin
            match_next = occ && (((data_reg ^ cmp_value) & cmp_mask) == '0);
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            data_next = prev_data;
        end
        else if (ctrl.push_back)
        begin
            // first free position behind the last entry
            if (prev_occ && !occ)
            begin
                data_next = wr_value;
            end
        end
        else if (ctrl.pop_front)
        begin
            data_next = next_data;
        end
        else if (ctrl.del)
        begin
            // everything from the first match backwards closes up
            if (found_out)
            begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_with_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_with_delete
// Bounded deque of DEPTH words with push/pop at both ends and delete by match
// ----------------------------------------------------------------------------
// A request on req carries an action and a value; every request gives one
// result on res with a status, the popped word and the entry count after it.
// The words sit in a row of cells, the front in the first cell; front pushes
// and pops shift the whole row one place, a back push writes the first free
// cell, a back pop only lowers the count, a delete closes up the row from the
// first matching cell. cfg writes the compare mask (all ones after reset) and
// is always ready; write it only while no request is in flight.
// Each request has an accept cycle, in which every cell compares its word
// with the request value, and an execute state that applies the action and
// loads the result register. A new request is taken in the cycle after
// execute, so the block takes no new request while one is still in flight.
// If res stalls, the result register holds; one further request may be
// accepted and waits in execute until the result register is free.
// Reset empties the queue and sets the mask; stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_with_delete #(
    parameter int DEPTH  = dqd_pkg::DEPTH_DEF,
    parameter int DATA_W = dqd_pkg::DATA_W_DEF
) (
    input  wire     clk,
    input  wire     rst_n,
    dqd_req_if.sink req,
    dqd_res_if.source res,
    dqd_cfg_if.sink cfg
);
    import dqd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t state_reg;
    state_t state_next;

    logic [ACTION_W-1:0] act_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [WORD_W-1:0]   mask_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [WORD_W-1:0]   out_popped_reg;
    logic [WORD_W-1:0]   out_popped_next;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [COUNT_W-1:0]  out_count_next;

    logic        accept;
    logic        exec_go;
    logic        full;
    logic        empty;
    cell_ctrl_t  ctrl;

    logic [DATA_W-1:0] cmp_value;
    logic [DATA_W-1:0] cmp_mask;

    logic [DEPTH+1:0]  occ_pad;
    logic [DATA_W-1:0] data_pad [DEPTH+2];
    logic [DEPTH:0]    found_chain;
    logic [DATA_W-1:0] tail_chain [DEPTH+1];
    logic [DEPTH-1:0]  last_vec;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || res.ready);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign cmp_value = DATA_W'(req.value);
    assign cmp_mask  = DATA_W'(mask_reg);

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.popped_value = out_popped_reg;
    assign res.entry_count  = out_count_reg;

    // padded neighbour views so the end cells need no special case
    assign occ_pad[0]         = 1'b1;
    assign occ_pad[DEPTH+1]   = 1'b0;
    assign data_pad[0]        = val_reg;
    assign data_pad[DEPTH+1]  = '0;
    assign found_chain[0]     = 1'b0;
    assign tail_chain[DEPTH]  = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ_pad[i+1] = (CNT_W'(i) < count_reg);

        dqd_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .cmp_value (cmp_value),
            .cmp_mask  (cmp_mask),
            .wr_value  (val_reg),
            .occ       (occ_pad[i+1]),
            .prev_occ  (occ_pad[i]),
            .next_occ  (occ_pad[i+2]),
            .prev_data (data_pad[i]),
            .next_data (data_pad[i+2]),
            .found_in  (found_chain[i]),
            .found_out (found_chain[i+1]),
            .tail_in   (tail_chain[i+1]),
            .tail_out  (tail_chain[i]),
            .is_last   (last_vec[i]),
            .data      (data_pad[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mask_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                mask_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            val_reg <= DATA_W'(req.value);
        end
        if (exec_go)
        begin
            out_status_reg <= out_status_next;
            out_popped_reg <= out_popped_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = STS_OK;
        out_popped_next = '0;
        ctrl            = '0;
        ctrl.sample     = accept;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    case (act_reg)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_status_next = STS_FULL;
                            end
                            else
                            begin
                                ctrl.push_front = 1'b1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_status_next = STS_FULL;
                            end
                            else
                            begin
                                ctrl.push_back = 1'b1;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_status_next = STS_EMPTY;
                            end
                            else
                            begin
                                ctrl.pop_front  = 1'b1;
                                out_popped_next = WORD_W'(data_pad[1]);
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_status_next = STS_EMPTY;
                            end
                            else
                            begin
                                out_popped_next = WORD_W'(tail_chain[0]);
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (found_chain[DEPTH])
                            begin
                                ctrl.del   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = STS_NOMATCH;
                            end
                        end
                        default:
                        begin
                            out_status_next = STS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_count_next = COUNT_W'(count_next);
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_single_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(last_vec))
        else $error("more than one cell marked as queue tail");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (ctrl.push_front || ctrl.push_back))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not add one entry");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && out_status_next == STS_EMPTY)
        |-> (empty && out_popped_next == '0))
        else $error("empty status on a non-empty queue");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && ctrl.del) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not remove one entry");

endmodule
`default_nettype wire
